[rtl/core/sfc_pkg.sv]
// Shared types, codes and reset values for the sphere frustum culler.
package sfc_pkg;

   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [1:0] {
      CULL_OUT     = 2'd0,
      CULL_IN      = 2'd1,
      CULL_PARTIAL = 2'd2
   } cull_type;

   // register indexes on the csr port
   localparam logic [3:0] REG_OFFSET_X = 4'd0;
   localparam logic [3:0] REG_OFFSET_Y = 4'd1;
   localparam logic [3:0] REG_WIDTH    = 4'd2;
   localparam logic [3:0] REG_HEIGHT   = 4'd3;
   localparam logic [3:0] REG_REGION   = 4'd4;
   localparam logic [3:0] REG_FOCUS    = 4'd5;
   localparam logic [3:0] REG_NEAR     = 4'd6;
   localparam logic [3:0] REG_FAR      = 4'd7;

   localparam logic [30:0] RST_SIZE   = 31'd131072;
   localparam logic [63:0] RST_REGION = 64'h8000_8000_0000_0000;
   localparam logic [30:0] RST_FOCUS  = 31'd65536;
   localparam logic [30:0] RST_NEAR   = 31'd6554;
   localparam logic [30:0] RST_FAR    = 31'd6553600;

   // side plane slots: left, right, bottom, top
   localparam logic [1:0] PLANE_LEFT   = 2'd0;
   localparam logic [1:0] PLANE_RIGHT  = 2'd1;
   localparam logic [1:0] PLANE_BOTTOM = 2'd2;
   localparam logic [1:0] PLANE_TOP    = 2'd3;

   typedef struct packed {
      logic [30:0] near_dist;
      logic [30:0] far_dist;
   } clip_type;

endpackage

[rtl/core/sphere_frustum_cull.sv]
// Sphere against view frustum classifier: top level.
//
// A sphere word (center, radius) enters on req_ when req_valid and req_ready
// are both high; one cull code word leaves on rsp_ per sphere, in order.
// Codes: out, in, partial.
// rsp_valid comes from the valid bit of the fourth stage, so a word passes
// stages 1 to 4, each registered, before it can be taken; one sphere is taken
// per cycle once the plane normals are ready and the receiver does not stall.
// The user must write the frustum registers on csr_ (csr_we, csr_index,
// csr_wdata) only while no sphere is in flight; the block does not enforce it.
// Each write, and reset, starts a derivation of the four side-plane normals:
// a start step, then per plane a border, square and sum step, a square root
// of one root bit per cycle, two divides, cosine then sine; req_ready stays
// low until it is done. When the receiver stalls, words pile up in the four
// stages, and req_ready falls only once every stage holds a word. Reset
// empties the pipeline.
module sphere_frustum_cull #(
   parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic [30:0]        req_sphere_radius,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_cull_code,
   input  logic               csr_we,
   input  logic [3:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import sfc_pkg::*;

   logic                      coef_ok;
   logic                      pipe_ready;
   logic [3:0][FRAC_BITS+1:0] cos_coef, sin_coef;
   clip_type                  clip;

   sfc_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef_ok   (coef_ok),
      .cos_coef  (cos_coef),
      .sin_coef  (sin_coef),
      .clip      (clip)
   );

   sfc_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid && coef_ok),
      .in_ready      (pipe_ready),
      .center_x      (req_center_x),
      .center_y      (req_center_y),
      .center_z      (req_center_z),
      .sphere_radius (req_sphere_radius),
      .cos_coef      (cos_coef),
      .sin_coef      (sin_coef),
      .clip          (clip),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_code      (rsp_cull_code)
   );

   assign req_ready = pipe_ready && coef_ok;

   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("sphere accepted right after a csr write");

   a_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cull_code == CULL_OUT || rsp_cull_code == CULL_IN ||
                     rsp_cull_code == CULL_PARTIAL))
      else $error("illegal cull code");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("pipeline not empty after reset");

endmodule

[rtl/core/sfc_coef.sv]
// Configuration registers and sequencer that derives the four side-plane normals.
module sfc_coef #(
   parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [3:0]                   csr_index,
   input  logic [63:0]                  csr_wdata,
   output logic                         coef_ok,
   output logic [3:0][FRAC_BITS+1:0]    cos_coef,
   output logic [3:0][FRAC_BITS+1:0]    sin_coef,
   output sfc_pkg::clip_type            clip
);
   import sfc_pkg::*;

   localparam int CW  = FRAC_BITS + 2;
   localparam int QW  = FRAC_BITS + 1;
   localparam int DCW = $clog2(QW);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_BORDER = 7'b0000010,
      ST_SQUARE = 7'b0000100,
      ST_SUM    = 7'b0001000,
      ST_ROOT   = 7'b0010000,
      ST_DIVC   = 7'b0100000,
      ST_DIVS   = 7'b1000000
   } seq_type;

   logic signed [31:0] offset_x_ff, offset_y_ff;
   logic [30:0]        width_ff, height_ff, focus_ff, near_ff, far_ff;
   logic [63:0]        region_ff;

   seq_type            state_ff, state_in;
   logic               dirty_ff, dirty_in;
   logic [1:0]         plane_ff, plane_in;
   logic signed [31:0] h_ff, h_in;
   logic [31:0]        habs_ff, habs_in;
   logic [61:0]        fsq_ff, fsq_in;
   logic [63:0]        hsq_ff, hsq_in;
   logic [63:0]        rad_ff, rad_in;
   logic [35:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic [4:0]         step_ff, step_in;
   logic [32:0]        dr_ff, dr_in;
   logic [QW-1:0]      q_ff, q_in;
   logic [DCW-1:0]     dcnt_ff, dcnt_in;
   logic [3:0][CW-1:0] cos_ff, cos_in, sin_ff, sin_in;

   logic signed [31:0] offset_sel;
   logic [30:0]        size_sel;
   logic [15:0]        frac_sel;
   logic signed [17:0] frac_diff;
   logic signed [49:0] bprod;
   logic signed [50:0] hsum;
   logic signed [31:0] hsat;
   logic [35:0]        rem_sh, trial;
   logic               root_ge;
   logic               abit, dnum_bit, div_ge;
   logic [32:0]        dr_sh;
   logic [QW-1:0]      q_new;
   logic [CW-1:0]      mag, quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         width_ff    <= RST_SIZE;
         height_ff   <= RST_SIZE;
         region_ff   <= RST_REGION;
         focus_ff    <= RST_FOCUS;
         near_ff     <= RST_NEAR;
         far_ff      <= RST_FAR;
      end else if (csr_we) begin
         case (csr_index)
            REG_OFFSET_X: offset_x_ff <= csr_wdata[31:0];
            REG_OFFSET_Y: offset_y_ff <= csr_wdata[31:0];
            REG_WIDTH:    width_ff    <= csr_wdata[30:0];
            REG_HEIGHT:   height_ff   <= csr_wdata[30:0];
            REG_REGION:   region_ff   <= csr_wdata;
            REG_FOCUS:    focus_ff    <= csr_wdata[30:0];
            REG_NEAR:     near_ff     <= csr_wdata[30:0];
            REG_FAR:      far_ff      <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // border offset of the current plane
   always_comb begin
      offset_sel = plane_ff[1] ? offset_y_ff : offset_x_ff;
      size_sel   = plane_ff[1] ? height_ff : width_ff;
      case (plane_ff)
         PLANE_LEFT:   frac_sel = region_ff[15:0];
         PLANE_RIGHT:  frac_sel = region_ff[47:32];
         PLANE_BOTTOM: frac_sel = region_ff[31:16];
         PLANE_TOP:    frac_sel = region_ff[63:48];
         default:      frac_sel = region_ff[15:0];
      endcase
      frac_diff = $signed({2'b00, frac_sel}) - 18'sd16384;
      bprod     = $signed({1'b0, size_sel}) * frac_diff;
      hsum      = 51'(offset_sel) + 51'(bprod >>> 15);
      if (hsum > 51'sd2147483647)
         hsat = 32'sh7FFF_FFFF;
      else if (hsum < -51'sd2147483648)
         hsat = 32'sh8000_0000;
      else
         hsat = hsum[31:0];
   end

   // one root bit and one quotient bit per cycle
   always_comb begin
      rem_sh   = {rem_ff[33:0], rad_ff[63:62]};
      trial    = {2'b00, root_ff, 2'b01};
      root_ge  = rem_sh >= trial;
      abit     = (state_ff == ST_DIVC) ? focus_ff[0] : habs_ff[0];
      dnum_bit = (dcnt_ff == DCW'(FRAC_BITS)) ? abit : 1'b0;
      dr_sh    = {dr_ff[31:0], dnum_bit};
      div_ge   = dr_sh >= {1'b0, root_ff};
      q_new    = q_ff;
      q_new[dcnt_ff] = div_ge;
      mag      = {1'b0, q_new};
      if (root_ff == '0)
         quot = '0;
      else if (state_ff == ST_DIVS && h_ff[31])
         quot = CW'(-mag);
      else
         quot = mag;
   end

   always_comb begin
      state_in = state_ff;
      dirty_in = dirty_ff;
      plane_in = plane_ff;
      h_in     = h_ff;
      habs_in  = habs_ff;
      fsq_in   = fsq_ff;
      hsq_in   = hsq_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      dr_in    = dr_ff;
      q_in     = q_ff;
      dcnt_in  = dcnt_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      case (state_ff)
         ST_IDLE: begin
            if (dirty_ff) begin
               dirty_in = 1'b0;
               plane_in = PLANE_LEFT;
               state_in = ST_BORDER;
            end
         end
         ST_BORDER: begin
            h_in     = hsat;
            habs_in  = hsat[31] ? 32'(-hsat) : hsat;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            fsq_in   = {31'b0, focus_ff} * {31'b0, focus_ff};
            hsq_in   = {32'b0, habs_ff} * {32'b0, habs_ff};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in   = {2'b00, fsq_ff} + hsq_ff;
            rem_in   = '0;
            root_in  = '0;
            step_in  = 5'd31;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = root_ge ? rem_sh - trial : rem_sh;
            root_in = {root_ff[30:0], root_ge};
            rad_in  = {rad_ff[61:0], 2'b00};
            step_in = step_ff - 5'd1;
            if (step_ff == '0) begin
               dr_in    = {3'b000, focus_ff[30:1]};
               q_in     = '0;
               dcnt_in  = DCW'(FRAC_BITS);
               state_in = ST_DIVC;
            end
         end
         ST_DIVC: begin
            dr_in   = div_ge ? dr_sh - {1'b0, root_ff} : dr_sh;
            q_in    = q_new;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               cos_in[plane_ff] = quot;
               dr_in    = {2'b00, habs_ff[31:1]};
               q_in     = '0;
               dcnt_in  = DCW'(FRAC_BITS);
               state_in = ST_DIVS;
            end
         end
         ST_DIVS: begin
            dr_in   = div_ge ? dr_sh - {1'b0, root_ff} : dr_sh;
            q_in    = q_new;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               sin_in[plane_ff] = quot;
               if (plane_ff == PLANE_TOP) begin
                  state_in = ST_IDLE;
               end else begin
                  plane_in = plane_ff + 2'd1;
                  state_in = ST_BORDER;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a write restarts the whole derivation
      if (csr_we) begin
         dirty_in = 1'b1;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dirty_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
      end
      plane_ff <= plane_in;
      h_ff     <= h_in;
      habs_ff  <= habs_in;
      fsq_ff   <= fsq_in;
      hsq_ff   <= hsq_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      step_ff  <= step_in;
      dr_ff    <= dr_in;
      q_ff     <= q_in;
      dcnt_ff  <= dcnt_in;
      cos_ff   <= cos_in;
      sin_ff   <= sin_in;
   end

   assign coef_ok        = (state_ff == ST_IDLE) && !dirty_ff;
   assign cos_coef       = cos_ff;
   assign sin_coef       = sin_ff;
   assign clip.near_dist = near_ff;
   assign clip.far_dist  = far_ff;

endmodule

[rtl/core/sfc_pipe.sv]
// Four-stage plane distance and classification pipeline.
module sfc_pipe #(
   parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [31:0]        center_x,
   input  logic signed [31:0]        center_y,
   input  logic signed [31:0]        center_z,
   input  logic [30:0]               sphere_radius,
   input  logic [3:0][FRAC_BITS+1:0] cos_coef,
   input  logic [3:0][FRAC_BITS+1:0] sin_coef,
   input  sfc_pkg::clip_type         clip,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [1:0]                out_code
);
   import sfc_pkg::*;

   localparam int PW  = FRAC_BITS + 34;
   localparam int CSW = 36;

   logic               a1, a2, a3, a4;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [PW-1:0]  pc_ff [4];
   logic signed [PW-1:0]  pz_ff [4];
   logic signed [CSW-1:0] cn_ff, cf_ff;
   logic [30:0]        r1_ff, r2_ff;
   logic signed [CSW-1:0] c_ff [6];
   logic               any_out_ff, all_in_ff;
   logic [1:0]         code_ff;
   logic               any_out_in, all_in_in;
   logic signed [CSW-1:0] c_in [6];

   assign a4 = !v4_ff || out_ready;
   assign a3 = !v3_ff || a4;
   assign a2 = !v2_ff || a3;
   assign a1 = !v1_ff || a2;
   assign in_ready = a1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (a1) v1_ff <= in_valid;
         if (a2) v2_ff <= v1_ff;
         if (a3) v3_ff <= v2_ff;
         if (a4) v4_ff <= v3_ff;
      end
   end

   // stage 1: products and clip plane distances
   always_ff @(posedge clock) begin
      if (a1 && in_valid) begin
         for (int k = 0; k < 4; k++) begin
            pc_ff[k] <= $signed(cos_coef[k]) * (k < 2 ? center_x : center_y);
            pz_ff[k] <= $signed(sin_coef[k]) * center_z;
         end
         cn_ff <= -CSW'(center_z) - $signed({5'b0, clip.near_dist});
         cf_ff <= CSW'(center_z) + $signed({5'b0, clip.far_dist});
         r1_ff <= sphere_radius;
      end
   end

   // stage 2: side plane sums, flip right and top, floor shift
   always_comb begin
      logic signed [PW:0] sumv;
      c_in[0] = cn_ff;
      c_in[1] = cf_ff;
      for (int k = 0; k < 4; k++) begin
         sumv = (PW+1)'(pc_ff[k]) + (PW+1)'(pz_ff[k]);
         if (k[0])
            sumv = -sumv;
         c_in[k+2] = CSW'(sumv >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (a2) begin
         c_ff  <= c_in;
         r2_ff <= r1_ff;
      end
   end

   // stage 3: per-plane tests against the radius
   always_comb begin
      logic signed [CSW:0] rr;
      rr = (CSW+1)'($signed({1'b0, r2_ff}));
      any_out_in = 1'b0;
      all_in_in  = 1'b1;
      for (int k = 0; k < 6; k++) begin
         if ((CSW+1)'(c_ff[k]) + rr < 0)
            any_out_in = 1'b1;
         if (!((CSW+1)'(c_ff[k]) - rr > 0))
            all_in_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a3) begin
         any_out_ff <= any_out_in;
         all_in_ff  <= all_in_in;
      end
   end

   // stage 4: output word
   always_ff @(posedge clock) begin
      if (a4) begin
         if (any_out_ff)
            code_ff <= CULL_OUT;
         else if (all_in_ff)
            code_ff <= CULL_IN;
         else
            code_ff <= CULL_PARTIAL;
      end
   end

   assign out_valid = v4_ff;
   assign out_code  = code_ff;

endmodule
